// ===== rtl/core/nvrdf_pkg.sv =====
// Shared types and constants for the recorder stream deframer.
`default_nettype none
package nvrdf_pkg;

    localparam logic [31:0] SIGNATURE   = 32'hFE01_0000;
    localparam logic [15:0] CODEC_H264  = 16'd26;
    localparam logic [15:0] CODEC_H265  = 16'd35;
    localparam logic [31:0] KEY_EXTRA   = 32'd16;
    localparam logic [31:0] AUDIO_EXTRA = 32'd5;
    localparam logic [31:0] TAIL_LEN    = 32'd4;
    localparam logic [4:0]  HEADER_LEN  = 5'd16;
    localparam logic [4:0]  SIG_BYTES   = 5'd4;

    localparam logic [15:0] H264_NALU_ISLICE = 16'd5;
    localparam logic [15:0] H264_NALU_SPS    = 16'd7;
    localparam logic [15:0] HEVC_KIND_IDR_RADL = 16'd19;
    localparam logic [15:0] HEVC_KIND_IDR_NLP  = 16'd20;
    localparam logic [15:0] HEVC_KIND_VPS      = 16'd32;
    localparam logic [15:0] HEVC_KIND_SPS      = 16'd33;

    localparam logic [1:0] KEY_FRAME_I     = 2'd1;
    localparam logic [1:0] KEY_FRAME_OTHER = 2'd2;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_EXTRA  = 5'b00100,
        PH_BODY   = 5'b01000,
        PH_TAIL   = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] sig_window;
        logic [4:0]  header_count;
        logic [15:0] codec_word;
        logic [15:0] kind_word;
        logic [15:0] gap_word;
        logic [31:0] length_word;
        logic [31:0] bytes_left;
        logic [31:0] time_base;
    } state_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [1:0]  key_frame;
        logic        is_hevc;
        logic [31:0] frame_time;
        logic        first_of_frame;
        logic        last_of_frame;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/nvrdf_step.sv =====
// Next-state and result logic for one stream word of the deframer.
`default_nettype none
module nvrdf_step (
    input  wire nvrdf_pkg::state_t  cur,
    input  wire logic [7:0]         data_byte,
    output nvrdf_pkg::state_t       nxt,
    output logic                    res_valid,
    output nvrdf_pkg::result_t      res
);

    always_comb begin
        logic [31:0] extra;
        logic [31:0] dec;
        logic [4:0]  cnt;
        logic [31:0] win;
        logic        video;
        logic        h264;
        logic        h265;

        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        extra     = '0;
        dec       = cur.bytes_left - 32'd1;
        cnt       = '0;
        win       = '0;
        video     = 1'b0;
        h264      = cur.codec_word == nvrdf_pkg::CODEC_H264;
        h265      = cur.codec_word == nvrdf_pkg::CODEC_H265;

        unique case (cur.phase)
            nvrdf_pkg::PH_HEADER: begin
                cnt = cur.header_count;
                if (cnt == 5'd4 || cnt == 5'd5) begin
                    nxt.codec_word = {data_byte, cur.codec_word[15:8]};
                end else if (cnt == 5'd6 || cnt == 5'd7) begin
                    nxt.kind_word = {data_byte, cur.kind_word[15:8]};
                end else if (cnt == 5'd8 || cnt == 5'd9) begin
                    nxt.gap_word = {data_byte, cur.gap_word[15:8]};
                end else if (cnt >= 5'd12) begin
                    nxt.length_word = {data_byte, cur.length_word[31:8]};
                end
                nxt.header_count = cnt + 5'd1;
                if (nxt.header_count >= nvrdf_pkg::HEADER_LEN) begin
                    // The header is complete: classify the frame from the new words.
                    h264  = nxt.codec_word == nvrdf_pkg::CODEC_H264;
                    h265  = nxt.codec_word == nvrdf_pkg::CODEC_H265;
                    video = h264 || h265;
                    if (h264) begin
                        if (nxt.kind_word == nvrdf_pkg::H264_NALU_ISLICE ||
                            nxt.kind_word == nvrdf_pkg::H264_NALU_SPS) begin
                            extra = nvrdf_pkg::KEY_EXTRA;
                        end
                    end else if (h265) begin
                        if (nxt.kind_word == nvrdf_pkg::HEVC_KIND_IDR_RADL ||
                            nxt.kind_word == nvrdf_pkg::HEVC_KIND_IDR_NLP ||
                            nxt.kind_word == nvrdf_pkg::HEVC_KIND_VPS ||
                            nxt.kind_word == nvrdf_pkg::HEVC_KIND_SPS) begin
                            extra = nvrdf_pkg::KEY_EXTRA;
                        end
                    end else begin
                        extra = nvrdf_pkg::AUDIO_EXTRA;
                    end
                    if (video) begin
                        nxt.time_base = cur.time_base + {16'd0, nxt.gap_word};
                    end
                    if (extra != 32'd0) begin
                        nxt.phase      = nvrdf_pkg::PH_EXTRA;
                        nxt.bytes_left = extra;
                    end else if (nxt.length_word == 32'd0) begin
                        nxt.phase      = nvrdf_pkg::PH_TAIL;
                        nxt.bytes_left = nvrdf_pkg::TAIL_LEN;
                    end else begin
                        nxt.phase      = nvrdf_pkg::PH_BODY;
                        nxt.bytes_left = nxt.length_word;
                    end
                end
            end
            nvrdf_pkg::PH_EXTRA: begin
                nxt.bytes_left = dec;
                if (dec == 32'd0) begin
                    if (cur.length_word == 32'd0) begin
                        nxt.phase      = nvrdf_pkg::PH_TAIL;
                        nxt.bytes_left = nvrdf_pkg::TAIL_LEN;
                    end else begin
                        nxt.phase      = nvrdf_pkg::PH_BODY;
                        nxt.bytes_left = cur.length_word;
                    end
                end
            end
            nvrdf_pkg::PH_BODY: begin
                if (h264 || h265) begin
                    res_valid          = 1'b1;
                    res.payload_byte   = data_byte;
                    res.key_frame      = (h264 && cur.kind_word == nvrdf_pkg::H264_NALU_ISLICE)
                                         ? nvrdf_pkg::KEY_FRAME_I
                                         : nvrdf_pkg::KEY_FRAME_OTHER;
                    res.is_hevc        = h265;
                    res.frame_time     = cur.time_base;
                    res.first_of_frame = cur.bytes_left == cur.length_word;
                    res.last_of_frame  = cur.bytes_left == 32'd1;
                end
                nxt.bytes_left = dec;
                if (dec == 32'd0) begin
                    nxt.phase      = nvrdf_pkg::PH_TAIL;
                    nxt.bytes_left = nvrdf_pkg::TAIL_LEN;
                end
            end
            nvrdf_pkg::PH_TAIL: begin
                nxt.bytes_left = dec;
                if (dec == 32'd0) begin
                    nxt.phase        = nvrdf_pkg::PH_HUNT;
                    nxt.sig_window   = '0;
                    nxt.header_count = '0;
                end
            end
            default: begin
                // Signature hunt: slide the window by one word at a time.
                win = {data_byte, cur.sig_window[31:8]};
                cnt = (cur.header_count < nvrdf_pkg::SIG_BYTES)
                      ? cur.header_count + 5'd1 : cur.header_count;
                nxt.phase        = nvrdf_pkg::PH_HUNT;
                nxt.sig_window   = win;
                nxt.header_count = cnt;
                if (cnt >= nvrdf_pkg::SIG_BYTES && win == nvrdf_pkg::SIGNATURE) begin
                    nxt.phase        = nvrdf_pkg::PH_HEADER;
                    nxt.header_count = nvrdf_pkg::SIG_BYTES;
                    nxt.codec_word   = '0;
                    nxt.kind_word    = '0;
                    nxt.gap_word     = '0;
                    nxt.length_word  = '0;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/nvrdf_out_stage.sv =====
// Result register of the deframer with its valid/ready handshake.
`default_nettype none
module nvrdf_out_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire nvrdf_pkg::result_t res_in,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output nvrdf_pkg::result_t      res_out,
    output logic                    can_accept
);

    logic               valid_reg;
    logic               valid_next;
    nvrdf_pkg::result_t res_reg;

    // A new word may enter whenever the held result is absent or leaves now.
    assign can_accept = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule
`default_nettype wire

// ===== rtl/core/nvr_frame_deframer_unit.sv =====
// Recorder stream deframer: finds frames in a byte stream and emits video payload.
//
// Input channel (s_valid, s_ready, s_data_byte) takes one stream word per
// accepted handshake. The block hunts for the frame signature, parses the
// 16-byte header, skips extra header and tail bytes, drops audio frames and
// emits each video payload byte on the result channel (m_valid, m_ready,
// m_payload_byte and frame attributes: key_frame, is_hevc, frame_time,
// first_of_frame, last_of_frame).
// Throughput is one word per clock while the receiver does not stall: all
// parsing for a word is combinational between the frame state registers and
// the result register. A result appears on m_valid at the clock edge that
// accepts the word that caused it. Words that cause no result are simply
// consumed.
// Reset (aresetn low, synchronous) clears the frame state, the time base and
// the result register valid, and puts the block back into signature hunt.
// When the receiver stalls with a result held, s_ready drops until the held
// result is taken; it stays high in the cycle the result leaves.
`default_nettype none
module nvr_frame_deframer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_payload_byte,
    output logic [1:0]       m_key_frame,
    output logic             m_is_hevc,
    output logic [31:0]      m_frame_time,
    output logic             m_first_of_frame,
    output logic             m_last_of_frame
);

    nvrdf_pkg::state_t  state_reg;
    nvrdf_pkg::state_t  state_next;
    nvrdf_pkg::result_t step_res;
    nvrdf_pkg::result_t out_res;
    logic               step_valid;
    logic               in_fire;
    logic               can_accept;

    assign s_ready = can_accept;
    assign in_fire = s_valid && can_accept;

    nvrdf_step u_step (
        .cur       (state_reg),
        .data_byte (s_data_byte),
        .nxt       (state_next),
        .res_valid (step_valid),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: nvrdf_pkg::PH_HUNT, default: '0};
        end else if (in_fire) begin
            state_reg <= state_next;
        end
    end

    nvrdf_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (in_fire && step_valid),
        .res_in     (step_res),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .res_out    (out_res),
        .can_accept (can_accept)
    );

    assign m_payload_byte   = out_res.payload_byte;
    assign m_key_frame      = out_res.key_frame;
    assign m_is_hevc        = out_res.is_hevc;
    assign m_frame_time     = out_res.frame_time;
    assign m_first_of_frame = out_res.first_of_frame;
    assign m_last_of_frame  = out_res.last_of_frame;

endmodule
`default_nettype wire
